// ===== src/timeout_table_timer_defines.svh =====
`ifndef TIMEOUT_TABLE_TIMER_DEFINES_SVH
`define TIMEOUT_TABLE_TIMER_DEFINES_SVH

// check a property on every rising edge outside reset
`define TTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising edge, reset included
`define TTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ttt_pkg.sv =====
`default_nettype none

package ttt_pkg;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_REGISTER = 2'd1;
  localparam logic [1:0] CMD_CANCEL   = 2'd2;

  localparam int SLOT_ADDR_W = 8;
  localparam int EXT_W       = 9;

  typedef struct packed {
    logic                   exp_we;
    logic                   cfg_we;
    logic [SLOT_ADDR_W-1:0] addr;
    logic [31:0]            expiry;
    logic [30:0]            period;
    logic [31:0]            word;
  } slot_wr_t;

  typedef struct packed {
    logic                   en;
    logic [SLOT_ADDR_W-1:0] addr;
  } slot_rd_t;

endpackage

`default_nettype wire

// ===== src/timeout_table_timer.sv =====
// Timeout table timer. Register (cmd 1) and cancel (cmd 2) items are
// accepted without raising in_stall and produce no result. A tick item
// (cmd 0) advances the time count and then walks the slot table once, one
// slot per cycle while out_stall holds back no result, through the slot
// memory read port and one shared compare, holding in_stall high throughout.
// Expired slots are delivered in ascending handle order; last_of_tick marks
// the final result of a tick, and a tick with no expiry delivers nothing.
`default_nettype none

module timeout_table_timer
  import ttt_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [3:0]  slot_handle,
  input  wire logic [30:0] interval,
  input  wire logic [30:0] reload_period,
  input  wire logic [31:0] user_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       expired_slot,
  output logic [31:0]      stored_value,
  output logic             rearmed,
  output logic             last_of_tick
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]            state;
  logic [31:0]           now_count;
  logic [SLOT_COUNT-1:0] armed;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_more;
  logic [IDX_W-1:0]      chk_idx;
  logic                  chk_valid;
  logic                  pend_valid;
  logic [IDX_W-1:0]      pend_idx;
  logic [31:0]           pend_word;
  logic                  pend_re;

  logic [31:0] rd_expiry;
  logic [30:0] rd_period;
  logic [31:0] rd_word;

  slot_wr_t wr;
  slot_rd_t rd;

  logic             in_fire;
  logic             handle_ok;
  logic [EXT_W-1:0] hnd_ext;
  logic [IDX_W-1:0] hnd_idx;
  logic [EXT_W-1:0] pend_ext;
  logic [31:0]      diff;
  logic [31:0]      sum_b;
  logic [31:0]      sum;
  logic             hit;
  logic             re;
  logic             can_push;
  logic             advance;
  logic             push_mid;
  logic             push_last;

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign hnd_ext   = EXT_W'(slot_handle);
  assign hnd_idx   = hnd_ext[IDX_W-1:0];
  assign handle_ok = (hnd_ext < EXT_W'(SLOT_COUNT));
  assign pend_ext  = EXT_W'(pend_idx);

  assign diff      = now_count - rd_expiry;
  assign hit       = chk_valid && armed[chk_idx] && !diff[31];
  assign re        = (rd_period != 31'd0);
  assign sum_b     = (state == ST_IDLE) ? {1'b0, interval} : {1'b0, rd_period};
  assign sum       = now_count + sum_b;

  assign can_push  = !out_valid || !out_stall;
  assign advance   = !(hit && pend_valid && !can_push);
  assign push_mid  = (state == ST_SCAN) && advance && hit && pend_valid;
  assign push_last = (state == ST_FLUSH) && pend_valid && can_push;

  always_comb begin
    wr.cfg_we = in_fire && (cmd == CMD_REGISTER) && handle_ok;
    wr.exp_we = wr.cfg_we || ((state == ST_SCAN) && advance && hit && re);
    wr.addr   = (state == ST_IDLE) ? SLOT_ADDR_W'(hnd_idx) : SLOT_ADDR_W'(chk_idx);
    wr.expiry = sum;
    wr.period = reload_period;
    wr.word   = user_value;
    rd.en     = (state == ST_SCAN) && advance && rd_more;
    rd.addr   = SLOT_ADDR_W'(rd_idx);
  end

  ttt_slot_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk       (clk),
    .wr        (wr),
    .rd        (rd),
    .rd_expiry (rd_expiry),
    .rd_period (rd_period),
    .rd_word   (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      now_count  <= 32'd0;
      armed      <= '0;
      rd_idx     <= '0;
      rd_more    <= 1'b0;
      chk_idx    <= '0;
      chk_valid  <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_valid <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (cmd)
              CMD_TICK: begin
                now_count  <= now_count + 32'd1;
                rd_idx     <= '0;
                rd_more    <= 1'b1;
                chk_valid  <= 1'b0;
                pend_valid <= 1'b0;
                state      <= ST_SCAN;
              end
              CMD_REGISTER: begin
                if (handle_ok) begin
                  armed[hnd_idx] <= 1'b1;
                end
              end
              CMD_CANCEL: begin
                if (handle_ok) begin
                  armed[hnd_idx] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (advance) begin
            chk_valid <= rd_more;
            chk_idx   <= rd_idx;
            if (rd_more) begin
              rd_idx  <= rd_idx + IDX_W'(1);
              rd_more <= (rd_idx != IDX_W'(SLOT_COUNT - 1));
            end
            if (hit) begin
              if (!re) begin
                armed[chk_idx] <= 1'b0;
              end
              pend_valid <= 1'b1;
            end
            if (!chk_valid && !rd_more) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (can_push) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // hold the pending result and the output item
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && advance && hit) begin
      pend_idx  <= chk_idx;
      pend_word <= rd_word;
      pend_re   <= re;
    end
    if (push_mid || push_last) begin
      expired_slot <= pend_ext[3:0];
      stored_value <= pend_word;
      rearmed      <= pend_re;
      last_of_tick <= push_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/ttt_slot_store.sv =====
`default_nettype none

module ttt_slot_store
  import ttt_pkg::*;
#(
  parameter int SLOT_COUNT = 16,
  parameter int IDX_W      = 4
) (
  input  wire logic        clk,
  input  wire slot_wr_t    wr,
  input  wire slot_rd_t    rd,
  output logic [31:0]      rd_expiry,
  output logic [30:0]      rd_period,
  output logic [31:0]      rd_word
);

  logic [31:0] expiry_mem [SLOT_COUNT];
  logic [30:0] period_mem [SLOT_COUNT];
  logic [31:0] word_mem   [SLOT_COUNT];

  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  assign wr_idx = wr.addr[IDX_W-1:0];
  assign rd_idx = rd.addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.exp_we) begin
      expiry_mem[wr_idx] <= wr.expiry;
    end
    if (wr.cfg_we) begin
      period_mem[wr_idx] <= wr.period;
      word_mem[wr_idx]   <= wr.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_expiry <= expiry_mem[rd_idx];
      rd_period <= period_mem[rd_idx];
      rd_word   <= word_mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

// ===== src/ttt_checker.sv =====
`default_nettype none

`include "timeout_table_timer_defines.svh"

module ttt_checker
  import ttt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  cmd,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  expired_slot,
  input wire logic [31:0] stored_value,
  input wire logic        rearmed,
  input wire logic        last_of_tick
);

  `TTT_ASSERT(a_tick_busy, (in_valid && !in_stall && cmd == CMD_TICK) |=> in_stall, "tick item did not start a scan")
  `TTT_ASSERT(a_cmd_one_cycle, (in_valid && !in_stall && cmd != CMD_TICK) |=> !in_stall, "register or cancel item held the block busy")
  `TTT_ASSERT(a_result_from_scan, $rose(out_valid) |-> $past(in_stall), "result item appeared outside a scan")
  `TTT_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(expired_slot) && $stable(stored_value) && $stable(rearmed) && $stable(last_of_tick)), "stalled result item changed")
  `TTT_ASSERT_ALWAYS(a_reset_idle, rst |=> (!out_valid && !in_stall), "block not idle after reset")

endmodule

bind timeout_table_timer ttt_checker u_ttt_checker (.*);

`default_nettype wire
